@@ rtl/core/timed_event_table_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the timed event table.
// Shared checker forms, each expanded on a line of its own.
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_TABLE_ASSERT_SVH
`define TIMED_EVENT_TABLE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define TET_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("timed event table check failed");

// An antecedent that must be accompanied by a consequent in the same cycle.
`define TET_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timed event table check failed");

`endif

@@ rtl/core/tet_pkg.sv @@
// ----------------------------------------------------------------------------
// Timed event table package
// Field widths, operation and status codes, payload structs and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tet_pkg;

    localparam int unsigned KIND_W    = 2;
    localparam int unsigned LIGHT_W   = 8;
    localparam int unsigned DAY_W     = 3;
    localparam int unsigned MIN_W     = 11;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned EVT_CNT_W = 5;

    // Operation codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRIGGER = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Day code that matches every day.
    localparam logic [DAY_W-1:0] DAY_EVERY = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [LIGHT_W-1:0] light_num;
        logic [DAY_W-1:0]   day;
        logic [MIN_W-1:0]   minute;
        logic               turn_on;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 command_valid;
        logic [LIGHT_W-1:0]   cmd_light;
        logic                 cmd_on;
        logic                 last_of_run;
        logic                 has_newest;
        logic [LIGHT_W-1:0]   newest_light;
        logic [DAY_W-1:0]     newest_day;
        logic [MIN_W-1:0]     newest_minute;
        logic                 newest_on;
        logic [EVT_CNT_W-1:0] event_count;
    } t_out_item;

    // One stored event, 23 bits.
    typedef struct packed {
        logic               turn_on;
        logic [MIN_W-1:0]   minute;
        logic [DAY_W-1:0]   day;
        logic [LIGHT_W-1:0] light;
    } t_event;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic scan_start;
        logic scan_step;
        logic shift_start;
        logic shift_step;
        logic add_write;
        logic count_dec;
        logic set_dup;
        logic set_full;
        logic new_rd;
        logic new_ld;
        logic take_pend;
        logic emit_pend;
        logic emit_final;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              key_hit;
        logic              trig_hit;
        logic              scan_end;
        logic              pend_valid;
        logic              out_free;
    } t_dp_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_ADD_WR,
        S_SHIFT,
        S_NEW_RD,
        S_NEW_LD,
        S_FINAL
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/tet_datapath.sv @@
// ----------------------------------------------------------------------------
// Timed event table datapath
// Event memory, scan pipeline, request and result registers. Acts on the
// commands of the controller and reports compare and scan status.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timed_event_table_assert.svh"

module tet_datapath #(
    parameter int unsigned MAX_EVENTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tet_pkg::t_in_item  i_in_item,
    input  tet_pkg::t_dp_cmd   i_cmd,
    output tet_pkg::t_dp_sts   o_sts,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output tet_pkg::t_out_item o_out_item
);
    import tet_pkg::*;

    localparam int unsigned CW = $clog2(MAX_EVENTS + 1);
    localparam int unsigned IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam logic [CW-1:0] MaxCount = CW'(MAX_EVENTS);

    t_event             mem [MAX_EVENTS];
    t_in_item           r_req;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_ptr;
    logic               r_rv;
    logic [IW-1:0]      r_cidx;
    t_event             r_rd_data;
    t_event             r_newest;
    logic [STATUS_W-1:0] r_status;
    logic               r_pend_valid;
    logic [LIGHT_W-1:0] r_pend_light;
    logic               r_pend_on;
    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;

    t_event             key;
    logic               advance;
    logic               ptr_in_range;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    t_event             wr_data;
    logic [CW-1:0]      last_idx;
    logic               out_free;
    logic               out_load;
    logic               has_newest;
    logic               day_match;

    // Request fields as a stored event, for compares and appends.
    assign key.turn_on = r_req.turn_on;
    assign key.minute  = r_req.minute;
    assign key.day     = r_req.day;
    assign key.light   = r_req.light_num;

    assign advance      = i_cmd.scan_step | i_cmd.shift_step;
    assign ptr_in_range = (r_ptr < r_count);
    assign last_idx     = r_count - CW'(1);
    assign out_free     = !r_out_valid || !i_out_stall;
    assign out_load     = i_cmd.emit_pend | i_cmd.emit_final;
    assign has_newest   = (r_count != '0);
    assign day_match    = (r_rd_data.day == r_req.day) || (r_rd_data.day == DAY_EVERY);

    // Read port selection: the newest entry or the scan pointer.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_ptr[IW-1:0];
        if (i_cmd.new_rd) begin
            rd_en   = 1'b1;
            rd_addr = last_idx[IW-1:0];
        end else if (advance) begin
            rd_en   = ptr_in_range;
        end
    end

    // Write port selection: append at the end or close a gap.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IW-1:0];
        wr_data = key;
        if (i_cmd.add_write) begin
            wr_en = 1'b1;
        end else if (i_cmd.shift_step && r_rv) begin
            wr_en   = 1'b1;
            wr_addr = r_cidx - IW'(1);
            wr_data = r_rd_data;
        end
    end

    // Event memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Request, newest entry and pending command payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_in_item;
        end
        if (i_cmd.new_ld) begin
            r_newest <= r_rd_data;
        end
        if (i_cmd.take_pend) begin
            r_pend_light <= r_rd_data.light;
            r_pend_on    <= r_rd_data.turn_on;
        end
        if (advance) begin
            r_cidx <= r_ptr[IW-1:0];
        end
        if (i_cmd.load_req) begin
            r_status <= ST_OK;
        end else if (i_cmd.set_dup) begin
            r_status <= ST_DUP;
        end else if (i_cmd.set_full) begin
            r_status <= ST_FULL;
        end
    end

    // Event count, scan pointer and pending flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_ptr        <= '0;
            r_rv         <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cmd.add_write) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - CW'(1);
            end

            if (i_cmd.scan_start) begin
                r_ptr <= '0;
                r_rv  <= 1'b0;
            end else if (i_cmd.shift_start) begin
                r_ptr <= CW'(r_cidx) + CW'(1);
                r_rv  <= 1'b0;
            end else if (advance) begin
                r_rv <= ptr_in_range;
                if (ptr_in_range) begin
                    r_ptr <= r_ptr + CW'(1);
                end
            end

            if (i_cmd.load_req) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.take_pend) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    // Next result transaction.
    always_comb begin
        n_out               = '0;
        n_out.has_newest    = has_newest;
        n_out.newest_light  = has_newest ? r_newest.light   : '0;
        n_out.newest_day    = has_newest ? r_newest.day     : '0;
        n_out.newest_minute = has_newest ? r_newest.minute  : '0;
        n_out.newest_on     = has_newest ? r_newest.turn_on : 1'b0;
        n_out.event_count   = EVT_CNT_W'(r_count);
        if (i_cmd.emit_pend) begin
            n_out.status        = ST_OK;
            n_out.command_valid = 1'b1;
            n_out.cmd_light     = r_pend_light;
            n_out.cmd_on        = r_pend_on;
            n_out.last_of_run   = 1'b0;
        end else begin
            n_out.status        = r_status;
            n_out.command_valid = r_pend_valid;
            n_out.cmd_light     = r_pend_valid ? r_pend_light : '0;
            n_out.cmd_on        = r_pend_valid ? r_pend_on : 1'b0;
            n_out.last_of_run   = 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Status toward the controller.
    assign o_sts.kind       = r_req.kind;
    assign o_sts.full       = (r_count >= MaxCount);
    assign o_sts.key_hit    = r_rv && (r_rd_data == key);
    assign o_sts.trig_hit   = r_rv && day_match && (r_rd_data.minute == r_req.minute);
    assign o_sts.scan_end   = !r_rv && !ptr_in_range;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = out_free;

    // The table never holds more events than it has room for.
    `TET_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= MaxCount)
    // A waiting result is never overwritten.
    `TET_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, out_load, out_free)
    // An append only happens while there is room.
    `TET_ASSERT_IMPL(a_add_room, i_clk, i_rst_n, i_cmd.add_write, r_count < MaxCount)
    // A gap close always moves an entry down from a nonzero slot.
    `TET_ASSERT_IMPL(a_shift_addr, i_clk, i_rst_n, i_cmd.shift_step && r_rv, r_cidx != '0)

endmodule

`default_nettype wire

@@ rtl/core/tet_ctrl.sv @@
// ----------------------------------------------------------------------------
// Timed event table controller
// Sequences add, remove and trigger transactions over the datapath:
// table scan, append, gap close, newest-entry read and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module tet_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  tet_pkg::t_dp_sts i_sts,
    output tet_pkg::t_dp_cmd o_cmd
);
    import tet_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   is_trig;
    logic   is_add;

    assign is_trig = (i_sts.kind == KIND_TRIGGER);
    assign is_add  = (i_sts.kind == KIND_ADD);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.kind)
                    KIND_ADD:    n_state = i_sts.full ? S_NEW_RD : S_SCAN;
                    KIND_REMOVE: n_state = S_SCAN;
                    default:     n_state = S_NEW_RD;
                endcase
            end
            S_SCAN: begin
                if (is_trig) begin
                    if (i_sts.scan_end) begin
                        n_state = S_FINAL;
                    end
                end else if (i_sts.key_hit) begin
                    n_state = is_add ? S_NEW_RD : S_SHIFT;
                end else if (i_sts.scan_end) begin
                    n_state = is_add ? S_ADD_WR : S_NEW_RD;
                end
            end
            S_ADD_WR: n_state = S_NEW_RD;
            S_SHIFT: begin
                if (i_sts.scan_end) begin
                    n_state = S_NEW_RD;
                end
            end
            S_NEW_RD: n_state = S_NEW_LD;
            S_NEW_LD: n_state = is_trig ? S_SCAN : S_FINAL;
            S_FINAL: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.load_req = i_in_valid;
            S_DISPATCH: begin
                if (is_add && i_sts.full) begin
                    o_cmd.set_full = 1'b1;
                end else if (is_add || (i_sts.kind == KIND_REMOVE)) begin
                    o_cmd.scan_start = 1'b1;
                end
            end
            S_SCAN: begin
                if (is_trig) begin
                    // Hold the scan while a match waits for the output register.
                    if (!i_sts.scan_end &&
                        !(i_sts.trig_hit && i_sts.pend_valid && !i_sts.out_free)) begin
                        o_cmd.scan_step = 1'b1;
                        o_cmd.take_pend = i_sts.trig_hit;
                        o_cmd.emit_pend = i_sts.trig_hit && i_sts.pend_valid;
                    end
                end else if (i_sts.key_hit) begin
                    o_cmd.set_dup     = is_add;
                    o_cmd.shift_start = !is_add;
                end else if (!i_sts.scan_end) begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_ADD_WR: o_cmd.add_write = 1'b1;
            S_SHIFT: begin
                if (i_sts.scan_end) begin
                    o_cmd.count_dec = 1'b1;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_NEW_RD: o_cmd.new_rd = 1'b1;
            S_NEW_LD: begin
                o_cmd.new_ld     = 1'b1;
                o_cmd.scan_start = is_trig;
            end
            S_FINAL: o_cmd.emit_final = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/timed_event_table.sv @@
// ----------------------------------------------------------------------------
// Timed event table
// Ordered table of scheduled light events with add, remove and trigger.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time; input stall is high from the
// cycle after acceptance until the transaction is finished. An add to a
// full table skips the scan, a duplicate ends the scan at the match, and a
// remove that finds its entry moves the later entries down to close the
// gap. Input stall drops in the cycle after the last result is loaded.
// Transaction time grows with the number of stored events, as the scan
// reads one entry per cycle through the single read port of the event
// memory, and a trigger also pauses while its results wait to be taken.
// Add and remove give one result; a trigger gives one result per matching
// event, the last marked, or one result without a command.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_event_table #(
    parameter int unsigned MAX_EVENTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tet_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tet_pkg::t_out_item o_out_item
);
    import tet_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer.
    tet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Event memory and result path.
    tet_datapath #(
        .MAX_EVENTS (MAX_EVENTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
